// ===== rtl/ftlt_pkg.sv =====
package ftlt_pkg;

	// request codes
	localparam logic [1:0] REQ_QUERY  = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] handle;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

// ===== rtl/flow_tuple_lookup_table.sv =====
// Exact-match flow table, CAPACITY entries of {96-bit flow tuple, 32-bit handle}.
//
// Request channel (req_valid/req_ready): req_type selects query, insert or clear;
// the tuple fields form the key, handle_in is stored on insert. Code 3 is a no-op.
// Response channel (rsp_valid/rsp_ready): one item per request with hit,
// handle_out (handle on a query hit, else zero) and status (1 = insert refused,
// table full).
//
// Entries fill from index 0 upward and are only freed all at once by a clear, so
// a fill count stands in for per-entry valid bits. A query or insert reads the
// entry RAM one address a cycle and runs the key through a single 96-bit compare
// until it hits or passes the fill count.
// Clear and no-op go straight to the response; query and insert first scan the
// filled entries (at most CAPACITY). One request is processed at a time; req_ready
// is high only when the sequencer is idle.
// Reset empties the table at once (fill count to zero) and drops any pending
// response. A stalled receiver holds the response in the output register; the
// block may take the next request meanwhile but holds its result (and any table
// write) until the output register frees.
module flow_tuple_lookup_table #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [31:0] handle_in,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        hit,
	output logic [31:0] handle_out,
	output logic        status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	ftlt_pkg::state_t state_q, state_d;

	// request held for the whole operation
	logic [1:0]      req_q;
	ftlt_pkg::key_t  key_q;
	logic [31:0]     handle_q;

	// table: entries 0 .. count_q-1 are valid
	ftlt_pkg::entry_t entry_mem_q [CAPACITY];
	ftlt_pkg::entry_t entry_rd_q;
	logic [CW-1:0]    count_q;

	// scan pointer (issues reads) and compare stage (sees each read in the cycle after)
	logic [CW-1:0] scan_idx_q;
	logic          cmp_vld_q;
	logic [AW-1:0] cmp_idx_q;

	// scan outcome
	logic          found_q;
	logic [AW-1:0] found_idx_q;
	logic [31:0]   found_handle_q;

	// response register
	logic        rsp_valid_q;
	logic        hit_q;
	logic [31:0] handle_out_q;
	logic        status_q;

	logic          accept;
	logic          out_free;
	logic          scan_more;
	logic          cmp_match;
	logic          rd_en;
	logic          we;
	logic [AW-1:0] waddr;
	logic          count_inc;
	logic          count_clr;
	logic          load_rsp;
	logic          rsp_hit_d;
	logic [31:0]   rsp_handle_d;
	logic          rsp_status_d;
	ftlt_pkg::entry_t wdata;

	assign req_ready = (state_q == ftlt_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign scan_more = (scan_idx_q < count_q);
	assign cmp_match = (state_q == ftlt_pkg::ST_SCAN) && cmp_vld_q
		&& (entry_rd_q.key == key_q);
	assign wdata     = '{key: key_q, handle: handle_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftlt_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == ftlt_pkg::REQ_QUERY
						|| req_type == ftlt_pkg::REQ_INSERT) begin
						state_d = ftlt_pkg::ST_SCAN;
					end else begin
						state_d = ftlt_pkg::ST_RESP;
					end
				end
			end
			ftlt_pkg::ST_SCAN: begin
				// stop on a hit, or once every filled entry has been compared
				if (cmp_match || (!scan_more && !cmp_vld_q)) begin
					state_d = ftlt_pkg::ST_RESP;
				end
			end
			ftlt_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = ftlt_pkg::ST_IDLE;
				end
			end
			default: state_d = ftlt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en        = 1'b0;
		we           = 1'b0;
		waddr        = found_idx_q;
		count_inc    = 1'b0;
		count_clr    = 1'b0;
		load_rsp     = 1'b0;
		rsp_hit_d    = 1'b0;
		rsp_handle_d = '0;
		rsp_status_d = ftlt_pkg::STATUS_DONE;
		unique case (state_q)
			ftlt_pkg::ST_IDLE: ;
			ftlt_pkg::ST_SCAN: begin
				rd_en = scan_more;
			end
			ftlt_pkg::ST_RESP: begin
				if (out_free) begin
					load_rsp = 1'b1;
					unique case (req_q)
						ftlt_pkg::REQ_QUERY: begin
							rsp_hit_d    = found_q;
							rsp_handle_d = found_q ? found_handle_q : '0;
						end
						ftlt_pkg::REQ_INSERT: begin
							if (found_q) begin
								we = 1'b1;
							end else if (count_q < CW'(CAPACITY)) begin
								we        = 1'b1;
								waddr     = count_q[AW-1:0];
								count_inc = 1'b1;
							end else begin
								rsp_status_d = ftlt_pkg::STATUS_FULL;
							end
						end
						ftlt_pkg::REQ_CLEAR: begin
							count_clr = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftlt_pkg::ST_IDLE;
			count_q     <= '0;
			cmp_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= rd_en;
			if (count_clr) begin
				count_q <= '0;
			end else if (count_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, scan pointer and outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req_type;
			key_q      <= '{src_addr: src_addr, dst_addr: dst_addr,
				src_port: src_port, dst_port: dst_port};
			handle_q   <= handle_in;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (rd_en) begin
			scan_idx_q <= scan_idx_q + CW'(1);
		end
		cmp_idx_q <= scan_idx_q[AW-1:0];
		if (cmp_match) begin
			found_q        <= 1'b1;
			found_idx_q    <= cmp_idx_q;
			found_handle_q <= entry_rd_q.handle;
		end
	end

	// entry RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			entry_rd_q <= entry_mem_q[scan_idx_q[AW-1:0]];
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			hit_q        <= rsp_hit_d;
			handle_out_q <= rsp_handle_d;
			status_q     <= rsp_status_d;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign handle_out = handle_out_q;
	assign status     = status_q;

endmodule

// ===== rtl/ftlt_checker.sv =====
module ftlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        hit,
	input logic [31:0] handle_out,
	input logic        status
);

	// pending response holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(handle_out)
			&& $stable(status))
		else $error("response changed while stalled");

	// one item at a time: no new request right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a miss or non-query result carries a zero handle
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> handle_out == 32'd0)
		else $error("nonzero handle without hit");

	// a query hit never reports table full
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> status == 1'b0)
		else $error("hit with full status");

endmodule

bind flow_tuple_lookup_table ftlt_checker u_ftlt_checker (.*);

// ===== tb/sv/flow_tuple_lookup_table_tb.sv =====
`timescale 1ns / 100ps

module flow_tuple_lookup_table_tb;

	// Request code 3 has no name in the package; the block treats it as a no-op.
	localparam logic [1:0] REQ_NOP = 2'd3;

	localparam int DEPTH        = 64;   // table capacity, same as the instance
	localparam int PHASE_ITEMS  = 125;  // items per pacing phase at least, fill included
	localparam int QUIET_LIMIT  = 4000; // cycles with no item moving on either side
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	typedef struct packed {
		logic [1:0]      op;
		ftlt_pkg::key_t  key;
		logic [31:0]     handle;
	} flow_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] handle;
		logic        status;
	} flow_rsp_t;

	// One row of the directed table: the request, and a typed-in response where
	// the answer is obvious (empty table, insert, clear, no-op).
	typedef struct packed {
		flow_req_t req;
		logic      typed;
		flow_rsp_t rsp;
	} dir_row_t;

	localparam flow_rsp_t RSP_ZERO = '{hit: 1'b0, handle: 32'h0,
		status: ftlt_pkg::STATUS_DONE};

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  req_type;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] handle_in;
	logic        rsp_valid;
	logic        rsp_ready;
	logic        hit;
	logic [31:0] handle_out;
	logic        status;

	flow_tuple_lookup_table #(
		.CAPACITY(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.src_addr  (src_addr),
		.dst_addr  (dst_addr),
		.src_port  (src_port),
		.dst_port  (dst_port),
		.handle_in (handle_in),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.hit       (hit),
		.handle_out(handle_out),
		.status    (status)
	);

	// 8 ns period
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Shadow copy of the flow table, updated as each request is accepted.
	logic           tbl_valid [DEPTH];
	ftlt_pkg::key_t tbl_key   [DEPTH];
	logic [31:0]    tbl_handle[DEPTH];

	flow_rsp_t   pending_lookup_rsp_q[$];
	dir_row_t    dir_rows[$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int n_sent, n_checked, n_errors, n_hits, n_refused, n_clears, n_nops;
	int quiet_cycles;

	//------------------------------------------------------------------
	// Predictor: lookup, insert/overwrite, clear, no-op
	//------------------------------------------------------------------
	function automatic flow_rsp_t flow_table_apply(flow_req_t r);
		flow_rsp_t res;
		int        slot;
		res  = RSP_ZERO;
		slot = -1;
		if (r.op == ftlt_pkg::REQ_QUERY || r.op == ftlt_pkg::REQ_INSERT) begin
			for (int i = 0; i < DEPTH && slot < 0; i++)
				if (tbl_valid[i] && tbl_key[i] == r.key)
					slot = i;
		end
		case (r.op)
			ftlt_pkg::REQ_QUERY: begin
				if (slot >= 0) begin
					res.hit    = 1'b1;
					res.handle = tbl_handle[slot];
				end
			end
			ftlt_pkg::REQ_INSERT: begin
				// new key goes to the lowest free entry
				for (int i = 0; i < DEPTH && slot < 0; i++)
					if (!tbl_valid[i])
						slot = i;
				if (slot >= 0) begin
					tbl_valid[slot]  = 1'b1;
					tbl_key[slot]    = r.key;
					tbl_handle[slot] = r.handle;
				end else begin
					res.status = ftlt_pkg::STATUS_FULL;
				end
			end
			ftlt_pkg::REQ_CLEAR: begin
				for (int i = 0; i < DEPTH; i++)
					tbl_valid[i] = 1'b0;
			end
			default: ; // no-op leaves the table alone
		endcase
		return res;
	endfunction

	function automatic int table_used();
		int used;
		used = 0;
		for (int i = 0; i < DEPTH; i++)
			used += tbl_valid[i];
		return used;
	endfunction

	// Some valid entry, or -1 when the table is empty.
	function automatic int pick_valid();
		int start;
		start = $urandom_range(DEPTH - 1, 0);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[(start + i) % DEPTH])
				return (start + i) % DEPTH;
		return -1;
	endfunction

	function automatic ftlt_pkg::key_t fresh_key();
		return {$urandom, $urandom, 16'($urandom), 16'($urandom)};
	endfunction

	// Same tuple with one bit flipped: misses the compare by a single bit.
	function automatic ftlt_pkg::key_t near_miss(ftlt_pkg::key_t k);
		return k ^ (96'd1 << $urandom_range(95, 0));
	endfunction

	function automatic logic [31:0] fresh_handle();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 10)
			return 32'h0;
		if (roll < 20)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("[%0t] mismatch on %s at response %0d: got %h, want %h",
			$time, what, n_checked, got, want);
	endtask

	//------------------------------------------------------------------
	// Request driver. Payload changes at the falling edge; the item counts
	// as accepted at the rising edge where valid and ready are both high.
	// Valid is left high on return so back-to-back items never drop it.
	//------------------------------------------------------------------
	task automatic issue_req(input flow_req_t r, input logic typed, input flow_rsp_t typed_rsp);
		flow_rsp_t predicted;
		@(negedge clk);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= r.op;
		src_addr  <= r.key.src_addr;
		dst_addr  <= r.key.dst_addr;
		src_port  <= r.key.src_port;
		dst_port  <= r.key.dst_port;
		handle_in <= r.handle;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = flow_table_apply(r);
		pending_lookup_rsp_q = {pending_lookup_rsp_q, (typed ? typed_rsp : predicted)};
		n_sent++;
		n_hits    += predicted.hit;
		n_refused += (predicted.status == ftlt_pkg::STATUS_FULL);
		n_clears  += (r.op == ftlt_pkg::REQ_CLEAR);
		n_nops    += (r.op == REQ_NOP);
	endtask

	function automatic void add_row(input logic [1:0] op, input ftlt_pkg::key_t k,
			input logic [31:0] h, input logic typed);
		dir_row_t row;
		row.req   = '{op: op, key: k, handle: h};
		row.typed = typed;
		row.rsp   = RSP_ZERO;
		dir_rows  = {dir_rows, row};
	endfunction

	//------------------------------------------------------------------
	// Random episodes
	//------------------------------------------------------------------

	// Fill the table to capacity, then push on it: new keys must be refused,
	// an overwrite of a present key must still land, and the last slot must
	// be reachable by a full-length scan.
	task automatic run_fill();
		flow_req_t r;
		int        idx;
		r.op = ftlt_pkg::REQ_INSERT;
		while (table_used() < DEPTH) begin
			r.key    = fresh_key();
			r.handle = fresh_handle();
			issue_req(r, 1'b0, RSP_ZERO);
		end
		repeat (3) begin
			r.key    = fresh_key();
			r.handle = fresh_handle();
			issue_req(r, 1'b0, RSP_ZERO);
		end
		idx      = pick_valid();
		r.key    = tbl_key[idx];
		r.handle = fresh_handle();
		issue_req(r, 1'b0, RSP_ZERO);
		r.op  = ftlt_pkg::REQ_QUERY;
		r.key = tbl_key[DEPTH - 1];
		issue_req(r, 1'b0, RSP_ZERO);
		r.key = tbl_key[idx];
		issue_req(r, 1'b0, RSP_ZERO);
		r.key = near_miss(tbl_key[DEPTH - 1]);
		issue_req(r, 1'b0, RSP_ZERO);
	endtask

	// Queries and inserts over a small key pool so hits and overwrites are
	// common; the pool mixes resident keys, near misses and new keys. A few
	// clears, no-ops and stray queries are sprinkled in as noise.
	task automatic run_mixed(input int n_items);
		ftlt_pkg::key_t pool[8];
		flow_req_t      r;
		int             roll;
		int             idx;
		for (int j = 0; j < 8; j++) begin
			idx  = pick_valid();
			roll = $urandom_range(99, 0);
			if (idx >= 0 && roll < 45)
				pool[j] = tbl_key[idx];
			else if (idx >= 0 && roll < 65)
				pool[j] = near_miss(tbl_key[idx]);
			else
				pool[j] = fresh_key();
		end
		for (int n = 0; n < n_items; n++) begin
			roll     = $urandom_range(99, 0);
			r.key    = pool[$urandom_range(7, 0)];
			r.handle = fresh_handle();
			if (roll < 4) begin
				r.op = ftlt_pkg::REQ_CLEAR;
			end else if (roll < 8) begin
				r.op  = REQ_NOP;
				r.key = fresh_key();
			end else if (roll < 12) begin
				r.op  = ftlt_pkg::REQ_QUERY;
				r.key = fresh_key();
			end else if (roll < 55) begin
				r.op = ftlt_pkg::REQ_QUERY;
			end else begin
				r.op = ftlt_pkg::REQ_INSERT;
			end
			issue_req(r, 1'b0, RSP_ZERO);
		end
	endtask

	//------------------------------------------------------------------
	// Response side: random back-pressure, in-order check, watchdog
	//------------------------------------------------------------------
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99, 0) >= sink_stall_pct);

	always @(posedge clk) begin : check_rsp
		flow_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_lookup_rsp_q.size() == 0) begin
					report_mismatch("unexpected response", {31'h0, hit}, 32'h0);
				end else begin
					want = pending_lookup_rsp_q.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", {31'h0, hit}, {31'h0, want.hit});
					if (handle_out !== want.handle)
						report_mismatch("handle_out", handle_out, want.handle);
					if (status !== want.status)
						report_mismatch("status", {31'h0, status}, {31'h0, want.status});
				end
				n_checked++;
			end
			// a scan covers at most DEPTH entries, so a long silence means a hang
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no item moved for %0d cycles, %0d responses outstanding",
					$time, QUIET_LIMIT, pending_lookup_rsp_q.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	//------------------------------------------------------------------
	// Stimulus
	//------------------------------------------------------------------
	initial begin : stim
		ftlt_pkg::key_t k_zero, k_ones, k_a, k_b;
		int             phase_start;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_type  = ftlt_pkg::REQ_QUERY;
		src_addr  = '0;
		dst_addr  = '0;
		src_port  = '0;
		dst_port  = '0;
		handle_in = '0;
		rsp_ready = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i]  = 1'b0;
			tbl_key[i]    = '0;
			tbl_handle[i] = '0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		k_zero = '0;
		k_ones = '1;
		k_a    = {32'h0A00_0001, 32'hC0A8_0001, 16'd80, 16'd443};
		k_b    = {32'h0A00_0001, 32'hC0A8_0001, 16'd80, 16'd442}; // one port bit off k_a

		// Directed part. typed = 1 rows carry an all-zero expected response:
		// misses on an empty or cleared table, successful inserts, clear, no-op.
		add_row(ftlt_pkg::REQ_QUERY,  k_zero, 32'hFFFF_FFFF, 1'b1); // empty after reset
		add_row(ftlt_pkg::REQ_QUERY,  k_ones, 32'h0,         1'b1);
		add_row(ftlt_pkg::REQ_INSERT, k_zero, 32'hFFFF_FFFF, 1'b1); // extreme key, handle
		add_row(ftlt_pkg::REQ_INSERT, k_ones, 32'h0,         1'b1);
		add_row(ftlt_pkg::REQ_QUERY,  k_zero, 32'h0,         1'b0);
		add_row(ftlt_pkg::REQ_QUERY,  k_ones, 32'hFFFF_FFFF, 1'b0); // hit, zero handle
		add_row(ftlt_pkg::REQ_INSERT, k_a,    32'h1234_5678, 1'b1);
		add_row(ftlt_pkg::REQ_QUERY,  k_b,    32'h0,         1'b0); // near miss
		add_row(ftlt_pkg::REQ_INSERT, k_a,    32'h9ABC_DEF0, 1'b1); // overwrite
		add_row(ftlt_pkg::REQ_QUERY,  k_a,    32'h0,         1'b0);
		add_row(REQ_NOP,              k_a,    32'hFFFF_FFFF, 1'b1); // unused code
		add_row(ftlt_pkg::REQ_QUERY,  k_a,    32'h0,         1'b0);
		add_row(ftlt_pkg::REQ_CLEAR,  k_ones, 32'hFFFF_FFFF, 1'b1);
		add_row(ftlt_pkg::REQ_QUERY,  k_a,    32'h0,         1'b1); // gone after clear
		add_row(ftlt_pkg::REQ_QUERY,  k_zero, 32'h0,         1'b1);
		add_row(ftlt_pkg::REQ_INSERT, k_b,    32'h0000_0005, 1'b1); // refills slot 0
		add_row(ftlt_pkg::REQ_QUERY,  k_b,    32'h0,         1'b0);
		add_row(ftlt_pkg::REQ_INSERT, k_a,    32'h0000_0006, 1'b1);
		add_row(ftlt_pkg::REQ_QUERY,  k_a,    32'h0,         1'b0);
		add_row(REQ_NOP,              k_ones, 32'hFFFF_FFFF, 1'b1);
		add_row(ftlt_pkg::REQ_QUERY,  k_ones, 32'h0,         1'b0);
		foreach (dir_rows[i])
			issue_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

		// Random part: four pacing phases, each a table fill plus mixed traffic.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 88;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 88;
				end
				default: begin
					src_idle_pct   = 10;
					sink_stall_pct = 10;
				end
			endcase
			phase_start = n_sent;
			run_fill();
			while (n_sent - phase_start < PHASE_ITEMS)
				run_mixed(20);
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// drain, then give a stray late response time to show up
		while (pending_lookup_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d query hits, %0d refused inserts, %0d clears, %0d no-ops",
			n_sent, n_hits, n_refused, n_clears, n_nops);
		$display("%0d responses checked over four pacing phases, %0d mismatches",
			n_checked, n_errors);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
